/* rtl/key_to_base58check_encoder_assert.svh */
// Assertion macros shared by the encoder modules.
`ifndef KEY_TO_BASE58CHECK_ENCODER_ASSERT_SVH
`define KEY_TO_BASE58CHECK_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define K2B_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define K2B_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define K2B_ASSERT_IMP(label, clk, rst_n, pre, post)
`define K2B_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/k2b_pkg.sv */
// Types, constants and functions shared by the encoder modules.
package k2b_pkg;

  localparam int unsigned NumChars = 51;
  localparam int unsigned NumBytes = 37;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned Base = 58;

  localparam logic [7:0] WifPrefix = 8'h80;

  typedef logic [5:0] rnd_t;
  typedef logic [5:0] chr_t;
  typedef logic [5:0] byt_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture key, init first hash
    logic round;     // run one compression round
    logic fin1;      // add H, set up second block
    logic fin2;      // add H, form the 296-bit value
    logic div_init;  // clear the remainder before a pass
    logic div_step;  // divide one byte
    logic dig_push;  // shift the pass remainder into the digit store
    logic emit;      // present one symbol
  } k2b_cmd_t;

  typedef struct packed {
    logic dummy;
  } k2b_sts_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input rnd_t i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [6:0] b58_char(input logic [5:0] d);
    logic [6:0] c;
    if (d < 6'd9) c = 7'd49 + {1'b0, d};
    else if (d < 6'd17) c = 7'd56 + {1'b0, d};
    else if (d < 6'd22) c = 7'd57 + {1'b0, d};
    else if (d < 6'd33) c = 7'd58 + {1'b0, d};
    else if (d < 6'd44) c = 7'd64 + {1'b0, d};
    else c = 7'd65 + {1'b0, d};
    return c;
  endfunction

endpackage

/* rtl/k2b_ctrl.sv */
// Sequencer for the two hashes, the division passes and the output.
module k2b_ctrl import k2b_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output k2b_cmd_t cmd,
  output logic     last
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_H1   = 7'b0000010,
    S_H2   = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_FIN2 = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  rnd_t   rnd_r, rnd_nxt;
  byt_t   byt_r, byt_nxt;
  chr_t   chr_r, chr_nxt;

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    byt_nxt = byt_r;
    chr_nxt = chr_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          rnd_nxt = '0;
          state_nxt = S_H1;
        end
      end
      S_H1: begin
        cmd.round = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(NumRounds - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin1 = 1'b1;
        state_nxt = S_H2;
      end
      S_H2: begin
        cmd.round = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(NumRounds - 1)) begin
          state_nxt = S_FIN2;
        end
      end
      S_FIN2: begin
        cmd.fin2 = 1'b1;
        byt_nxt = '0;
        chr_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        byt_nxt = byt_r + 6'd1;
        if (byt_r == 6'(NumBytes - 1)) begin
          cmd.dig_push = 1'b1;
          byt_nxt = '0;
          chr_nxt = chr_r + 6'd1;
          if (chr_r == 6'(NumChars - 1)) begin
            state_nxt = S_EMIT;
            chr_nxt = '0;
          end else begin
            cmd.div_init = 1'b1;
          end
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        chr_nxt = chr_r + 6'd1;
        if (chr_r == 6'(NumChars - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r <= '0;
      byt_r <= '0;
      chr_r <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      byt_r <= byt_nxt;
      chr_r <= chr_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign last = (state_r == S_EMIT) && (chr_r == 6'(NumChars - 1));

endmodule

/* rtl/k2b_dp.sv */
// SHA-256 round unit, divide-by-58 unit and digit store.
module k2b_dp import k2b_pkg::*; (
  input  logic        clk,
  input  k2b_cmd_t    cmd,
  input  logic [63:0] key_word_0,
  input  logic [63:0] key_word_1,
  input  logic [63:0] key_word_2,
  input  logic [63:0] key_word_3,
  output logic [6:0]  symbol
);

  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_nxt [16];
  logic [31:0] v_nxt [8];
  logic [31:0] h_nxt [8];
  rnd_t        rnd_r;
  logic [7:0]  num_r [NumBytes];
  logic [7:0]  num_nxt [NumBytes];
  logic [5:0]  rem_r, rem_nxt;
  logic [5:0]  dig_r [NumChars];
  logic [7:0]  key_b [32];
  logic [31:0] t1, t2, s0, s1, wn, sum [8];
  logic [13:0] cur;
  logic [7:0]  q;
  logic [5:0]  r;

  // Unpack key bytes, big-endian
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      key_b[j]      = key_word_0[63 - 8*j -: 8];
      key_b[8 + j]  = key_word_1[63 - 8*j -: 8];
      key_b[16 + j] = key_word_2[63 - 8*j -: 8];
      key_b[24 + j] = key_word_3[63 - 8*j -: 8];
    end
  end

  // One compression round with message schedule in a 16-word window
  always_comb begin
    t1 = v_r[7] + ({v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
         ^ {v_r[4][24:0], v_r[4][31:25]}) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + round_k(rnd_r) + w_r[0];
    t2 = ({v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
         ^ {v_r[0][21:0], v_r[0][31:22]})
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
         ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    for (int i = 0; i < 8; i++) sum[i] = h_r[i] + v_r[i];
  end

  // Divide one byte of the running value by 58
  always_comb begin
    cur = {rem_r, 8'h00} | 14'(num_r[0]);
    q = 8'((24'(cur) * 24'd565) >> 15);
    if (14'(cur - 14'(q) * 14'(Base)) >= 14'(Base)) q = q + 8'd1;
    r = 6'(cur - 14'(q) * 14'(Base));
  end

  // Sequence register updates
  always_comb begin
    for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i];
    for (int i = 0; i < 8; i++) begin
      v_nxt[i] = v_r[i];
      h_nxt[i] = h_r[i];
    end
    for (int i = 0; i < NumBytes; i++) num_nxt[i] = num_r[i];
    rem_nxt = rem_r;
    if (cmd.load) begin
      w_nxt[0] = {WifPrefix, key_b[0], key_b[1], key_b[2]};
      for (int i = 1; i < 8; i++)
        w_nxt[i] = {key_b[4*i-1], key_b[4*i], key_b[4*i+1], key_b[4*i+2]};
      w_nxt[8] = {key_b[31], 8'h80, 16'h0000};
      for (int i = 9; i < 15; i++) w_nxt[i] = '0;
      w_nxt[15] = 32'd264;
      for (int i = 0; i < 8; i++) begin
        v_nxt[i] = InitH[i];
        h_nxt[i] = InitH[i];
      end
      // Keep prefix and key for the division value
      num_nxt[0] = WifPrefix;
      for (int i = 0; i < 32; i++) num_nxt[1 + i] = key_b[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[15] = wn;
      v_nxt[0] = t1 + t2;
      v_nxt[1] = v_r[0];
      v_nxt[2] = v_r[1];
      v_nxt[3] = v_r[2];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[5] = v_r[4];
      v_nxt[6] = v_r[5];
      v_nxt[7] = v_r[6];
    end else if (cmd.fin1) begin
      for (int i = 0; i < 8; i++) begin
        w_nxt[i] = sum[i];
        v_nxt[i] = InitH[i];
        h_nxt[i] = InitH[i];
      end
      w_nxt[8] = 32'h80000000;
      for (int i = 9; i < 15; i++) w_nxt[i] = '0;
      w_nxt[15] = 32'd256;
    end else if (cmd.fin2) begin
      num_nxt[33] = sum[0][31:24];
      num_nxt[34] = sum[0][23:16];
      num_nxt[35] = sum[0][15:8];
      num_nxt[36] = sum[0][7:0];
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < NumBytes - 1; i++) num_nxt[i] = num_r[i + 1];
      num_nxt[NumBytes - 1] = q;
      rem_nxt = cmd.div_init ? 6'd0 : r;
    end
  end

  // Hold datapath registers; digits shift in least significant first
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
    for (int i = 0; i < 8; i++) begin
      v_r[i] <= v_nxt[i];
      h_r[i] <= h_nxt[i];
    end
    for (int i = 0; i < NumBytes; i++) num_r[i] <= num_nxt[i];
    rem_r <= rem_nxt;
    if (cmd.load || cmd.fin1) rnd_r <= '0;
    else if (cmd.round) rnd_r <= rnd_r + 6'd1;
    if (cmd.dig_push) begin
      dig_r[0] <= r;
      for (int i = 1; i < NumChars; i++) dig_r[i] <= dig_r[i - 1];
    end else if (cmd.emit) begin
      for (int i = 0; i < NumChars - 1; i++) dig_r[i] <= dig_r[i + 1];
    end
  end

  assign symbol = b58_char(dig_r[0]);

endmodule

/* rtl/key_to_base58check_encoder.sv */
// Top level: private key to 51-character Base58Check string.
// Usage:
//   Drive key_word_0..3 (big-endian key) and pulse start while busy is low;
//   the key transfers on that edge and is held inside the block.
//   The block hashes 0x80||key with SHA-256 in 64 rounds, one per cycle,
//   forms the second block, hashes it in 64 more rounds and forms the
//   296-bit value.
//   It then divides the 296-bit value by 58 one byte per cycle, 37 bytes
//   a digit, 51 digits.
//   Each of the 51 characters then appears on out_symbol for one cycle
//   with out_valid high, most significant first; out_last marks the 51st.
//   A new key is taken once busy is low again.
//   Reset (rst_n low, synchronous) returns the sequencer to idle.
//   The receiver cannot stall; every strobed symbol is a transfer.
module key_to_base58check_encoder import k2b_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_key_word_0,
  input  logic [63:0] in_key_word_1,
  input  logic [63:0] in_key_word_2,
  input  logic [63:0] in_key_word_3,
  output logic        out_valid,
  output logic [6:0]  out_symbol,
  output logic        out_last
);

`include "key_to_base58check_encoder_assert.svh"

  k2b_cmd_t cmd;
  logic     last_c;

  k2b_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .last  (last_c)
  );

  k2b_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .key_word_0 (in_key_word_0),
    .key_word_1 (in_key_word_1),
    .key_word_2 (in_key_word_2),
    .key_word_3 (in_key_word_3),
    .symbol     (out_symbol)
  );

  assign out_valid = cmd.emit;
  assign out_last  = last_c;

  `K2B_ASSERT_IMP(a_last_valid, clk, rst_n, out_last, out_valid)
  `K2B_ASSERT_IMP(a_emit_busy, clk, rst_n, out_valid, busy)
  `K2B_ASSERT_NXT(a_last_idle, clk, rst_n, out_last, !busy)

endmodule
